// ===== rtl/core/rop_pkg.sv =====
// Shared types and constants for the relocatable-object bit packer.
`default_nettype none

package rop_pkg;

  // Field widths of the input and output items.
  localparam int unsigned KindW    = 5;
  localparam int unsigned FtypeW   = 2;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned SlenW    = 4;
  localparam int unsigned CharsW   = 56;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned FreeW    = 4;
  localparam int unsigned InDataW  = 80;

  // Symbol defaults.
  localparam int unsigned MAX_SYMBOL_CHARS_DEF = 7;
  localparam int unsigned SYMBOL_LENGTH_BITS   = 3;

  // Item kinds.
  localparam logic [KindW-1:0] KIND_ABS      = 5'd0;
  localparam logic [KindW-1:0] KIND_REL_LAST = 5'd3;
  localparam logic [KindW-1:0] KIND_SPC_BASE = 5'd4;
  localparam logic [KindW-1:0] KIND_LAST     = 5'd19;

  // Special link item code boundaries.
  localparam logic [CodeW-1:0] CODE_SYM_LAST     = 4'd4;
  localparam logic [CodeW-1:0] CODE_VALSYM_LAST  = 4'd7;
  localparam logic [CodeW-1:0] CODE_VAL_LAST     = 4'd13;
  localparam logic [CodeW-1:0] CODE_END_PROGRAM  = 4'd14;

  // Leading bits of a special link item.
  localparam logic [2:0] SPC_PREFIX = 3'b100;

  // Count of free bit positions in an empty byte.
  localparam logic [FreeW-1:0] FREE_EMPTY = 4'd8;
  localparam logic [FreeW-1:0] FREE_ONE   = 4'd1;

  // Bit offered by the shifter to the byte assembler.
  typedef struct packed {
    logic bit_vld;
    logic bit_val;
    logic item_end;
  } rop_bit_t;

  // Status returned by the byte assembler.
  typedef struct packed {
    logic bit_rdy;
    logic end_rdy;
    logic aligned;
  } rop_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/rop_item_fmt.sv =====
// Formats one item into a left-aligned bit string and a bit count.
`default_nettype none

module rop_item_fmt #(
  parameter int unsigned MaxSymbolChars = rop_pkg::MAX_SYMBOL_CHARS_DEF,
  localparam int unsigned ShiftW = 28 + 8 * MaxSymbolChars,
  localparam int unsigned CntW   = $clog2(ShiftW + 1)
) (
  input  wire logic [rop_pkg::KindW-1:0]  kind_i,
  input  wire logic [rop_pkg::FtypeW-1:0] field_type_i,
  input  wire logic [rop_pkg::ValueW-1:0] value_i,
  input  wire logic [rop_pkg::SlenW-1:0]  symbol_length_i,
  input  wire logic [rop_pkg::CharsW-1:0] symbol_chars_i,
  output logic [ShiftW-1:0]               bits_o,
  output logic [CntW-1:0]                 count_o,
  output logic                            pad_o,
  output logic                            skip_o
);

  localparam int unsigned SymW = 8 * MaxSymbolChars;
  localparam logic [rop_pkg::SlenW-1:0] MaxLen = rop_pkg::SlenW'(MaxSymbolChars);

  logic [SymW-1:0]                 sym;
  logic [rop_pkg::SlenW-1:0]       len_clamp;
  logic [2:0]                      len;
  logic [rop_pkg::CodeW-1:0]       code;
  logic [7:0]                      vlo;
  logic [7:0]                      vhi;
  logic [CntW-1:0]                 sym_bits;

  // Symbol bytes, first character in the top byte so it is sent first.
  always_comb begin
    for (int i = 0; i < MaxSymbolChars; i++) begin
      sym[(MaxSymbolChars-1-i)*8 +: 8] = symbol_chars_i[i*8 +: 8];
    end
  end

  assign len_clamp = (symbol_length_i > MaxLen) ? MaxLen : symbol_length_i;
  assign len       = len_clamp[2:0];
  assign sym_bits  = CntW'({len, 3'b000});
  assign code      = rop_pkg::CodeW'(kind_i - rop_pkg::KIND_SPC_BASE);
  assign vlo       = value_i[7:0];
  assign vhi       = value_i[15:8];
  assign skip_o    = (kind_i > rop_pkg::KIND_LAST);

  // Encoding select by item kind and special code.
  always_comb begin
    bits_o  = '0;
    count_o = '0;
    pad_o   = 1'b0;
    if (kind_i == rop_pkg::KIND_ABS) begin
      bits_o  = {1'b0, vlo, {(ShiftW-9){1'b0}}};
      count_o = CntW'(9);
    end else if (kind_i <= rop_pkg::KIND_REL_LAST) begin
      bits_o  = {1'b1, kind_i[1:0], vlo, vhi, {(ShiftW-19){1'b0}}};
      count_o = CntW'(19);
    end else if (code <= rop_pkg::CODE_SYM_LAST) begin
      bits_o  = {rop_pkg::SPC_PREFIX, code, len, sym, {(ShiftW-10-SymW){1'b0}}};
      count_o = CntW'(10) + sym_bits;
    end else if (code <= rop_pkg::CODE_VALSYM_LAST) begin
      bits_o  = {rop_pkg::SPC_PREFIX, code, field_type_i, vlo, vhi, len, sym};
      count_o = CntW'(28) + sym_bits;
    end else if (code <= rop_pkg::CODE_END_PROGRAM) begin
      bits_o  = {rop_pkg::SPC_PREFIX, code, field_type_i, vlo, vhi,
                 {(ShiftW-25){1'b0}}};
      count_o = CntW'(25);
      pad_o   = (code == rop_pkg::CODE_END_PROGRAM);
    end else begin
      bits_o  = {rop_pkg::SPC_PREFIX, code, {(ShiftW-7){1'b0}}};
      count_o = CntW'(7);
      pad_o   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rop_bit_shifter.sv =====
// Shift register and sequencer that sends an item's bits one per cycle while the byte assembler takes them.
`default_nettype none

module rop_bit_shifter #(
  parameter int unsigned MaxSymbolChars = rop_pkg::MAX_SYMBOL_CHARS_DEF,
  localparam int unsigned ShiftW = 28 + 8 * MaxSymbolChars,
  localparam int unsigned CntW   = $clog2(ShiftW + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_vld_i,
  output logic                   in_rdy_o,
  input  wire logic [ShiftW-1:0] bits_i,
  input  wire logic [CntW-1:0]   count_i,
  input  wire logic              pad_i,
  input  wire logic              skip_i,
  output rop_pkg::rop_bit_t      bit_o,
  input  wire rop_pkg::rop_sts_t sts_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_PAD   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ShiftW-1:0] sreg_q, sreg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pad_q, pad_d;
  logic              bit_fire;

  assign in_rdy_o = (state_q == ST_IDLE);
  assign bit_fire = bit_o.bit_vld && sts_i.bit_rdy;

  // Bit offer to the byte assembler.
  always_comb begin
    bit_o          = '0;
    bit_o.item_end = (state_q == ST_FLUSH);
    if (state_q == ST_SHIFT) begin
      bit_o.bit_vld = 1'b1;
      bit_o.bit_val = sreg_q[ShiftW-1];
    end else if (state_q == ST_PAD) begin
      bit_o.bit_vld = !sts_i.aligned;
    end
  end

  // Sequencer: load, shift, optional padding, then flush the last byte.
  always_comb begin
    state_d = state_q;
    sreg_d  = sreg_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_vld_i && !skip_i) begin
          sreg_d  = bits_i;
          cnt_d   = count_i;
          pad_d   = pad_i;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (bit_fire) begin
          sreg_d = {sreg_q[ShiftW-2:0], 1'b0};
          cnt_d  = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = pad_q ? ST_PAD : ST_FLUSH;
          end
        end
      end
      ST_PAD: begin
        if (sts_i.aligned) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.end_rdy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
  end

  // The bit counter never runs dry while shifting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (cnt_q != '0))
    else $error("shift state with empty bit counter");

endmodule

`default_nettype wire

// ===== rtl/core/rop_byte_asm.sv =====
// Collects bits into bytes, holds the newest byte and drives the output register.
`default_nettype none

module rop_byte_asm (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rop_pkg::rop_bit_t         bit_i,
  output rop_pkg::rop_sts_t              sts_o,
  output logic                           out_vld_o,
  input  wire logic                      out_rdy_i,
  output logic [rop_pkg::ByteW-1:0]      out_byte_o,
  output logic                           out_last_o
);

  logic [6:0]                    pend_q, pend_d;
  logic [rop_pkg::FreeW-1:0]     free_q, free_d;
  logic                          hold_vld_q, hold_vld_d;
  logic [rop_pkg::ByteW-1:0]     hold_q, hold_d;
  logic                          out_vld_q, out_vld_d;
  logic [rop_pkg::ByteW-1:0]     out_byte_q, out_byte_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free;
  logic                          completes;
  logic                          bit_fire;
  logic                          end_fire;
  logic                          out_load;

  assign out_free  = !out_vld_q || out_rdy_i;
  assign completes = (free_q == rop_pkg::FREE_ONE);

  assign sts_o.bit_rdy = !completes || !hold_vld_q || out_free;
  assign sts_o.end_rdy = !hold_vld_q || out_free;
  assign sts_o.aligned = (free_q == rop_pkg::FREE_EMPTY);

  assign bit_fire = bit_i.bit_vld && sts_o.bit_rdy;
  assign end_fire = bit_i.item_end && sts_o.end_rdy;
  assign out_load = hold_vld_q && ((bit_fire && completes) || end_fire);

  // Byte assembly and the one-byte hold that waits to learn if it is last.
  always_comb begin
    pend_d     = pend_q;
    free_d     = free_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !out_rdy_i;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_byte_d = hold_q;
      out_last_d = end_fire;
    end
    if (bit_fire) begin
      if (completes) begin
        hold_d     = {pend_q, bit_i.bit_val};
        hold_vld_d = 1'b1;
        pend_d     = '0;
        free_d     = rop_pkg::FREE_EMPTY;
      end else begin
        pend_d = {pend_q[5:0], bit_i.bit_val};
        free_d = free_q - rop_pkg::FreeW'(1);
      end
    end else if (end_fire) begin
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      free_q     <= rop_pkg::FREE_EMPTY;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      free_q     <= free_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_vld_o  = out_vld_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

  // The free count always stays within one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q >= rop_pkg::FREE_ONE) && (free_q <= rop_pkg::FREE_EMPTY))
    else $error("free bit count out of range");

  // A held byte that ends an item leaves as the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_fire && hold_vld_q) |=> (out_vld_q && out_last_q && !hold_vld_q))
    else $error("item end did not flush the held byte as last");

  // A byte completed over a full hold pushes the older one out, not last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_fire && completes && hold_vld_q) |=> (out_vld_q && !out_last_q && hold_vld_q))
    else $error("completed byte lost the older held byte");

endmodule

`default_nettype wire

// ===== rtl/core/rel_object_item_bit_packer.sv =====
// Top level of the relocatable-object item bit packer.
//
//  Port group  Dir  Payload
//  s_axis      in   tuser: kind[4:0]; tdata: field_type, value, symbol_length,
//                   symbol_chars (80 bits)
//  m_axis      out  tdata: out_byte[7:0]; tlast: last
//
// An accepted item's encoded bits (7 to 84 bits) leave the shift register one
// per cycle while the byte assembler takes them; then its final byte is
// released, and only after that is the next item taken. End items first add
// zero pad bits (up to 7) until the byte is aligned.
// Reset empties the pending byte (8 free positions) and the output register.
// A full output register stalls the shifter when a completed byte must push out
// the held one, and at the end of an item while a byte is held.
// Items with kinds above 19 are accepted and produce nothing.
`default_nettype none

module rel_object_item_bit_packer #(
  parameter int unsigned MaxSymbolChars = rop_pkg::MAX_SYMBOL_CHARS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] field_type, [17:2] value, [21:18] symbol_length,
  // [77:22] symbol_chars, [79:78] zero
  input  wire logic [rop_pkg::InDataW-1:0]   s_axis_tdata,
  // [4:0] kind
  input  wire logic [rop_pkg::KindW-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] out_byte
  output logic [rop_pkg::ByteW-1:0]          m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int unsigned ShiftW = 28 + 8 * MaxSymbolChars;
  localparam int unsigned CntW   = $clog2(ShiftW + 1);

  logic [ShiftW-1:0]   fmt_bits;
  logic [CntW-1:0]     fmt_count;
  logic                fmt_pad;
  logic                fmt_skip;
  rop_pkg::rop_bit_t   bit_link;
  rop_pkg::rop_sts_t   sts_link;

  // Item encoding.
  rop_item_fmt #(
    .MaxSymbolChars (MaxSymbolChars)
  ) u_fmt (
    .kind_i          (s_axis_tuser),
    .field_type_i    (s_axis_tdata[1:0]),
    .value_i         (s_axis_tdata[17:2]),
    .symbol_length_i (s_axis_tdata[21:18]),
    .symbol_chars_i  (s_axis_tdata[77:22]),
    .bits_o          (fmt_bits),
    .count_o         (fmt_count),
    .pad_o           (fmt_pad),
    .skip_o          (fmt_skip)
  );

  // Bit-serial sequencer.
  rop_bit_shifter #(
    .MaxSymbolChars (MaxSymbolChars)
  ) u_shift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (s_axis_tvalid),
    .in_rdy_o (s_axis_tready),
    .bits_i   (fmt_bits),
    .count_i  (fmt_count),
    .pad_i    (fmt_pad),
    .skip_i   (fmt_skip),
    .bit_o    (bit_link),
    .sts_i    (sts_link)
  );

  // Byte assembly and output register.
  rop_byte_asm u_asm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_i      (bit_link),
    .sts_o      (sts_link),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire
